@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the timed-wait expiry table RTL.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while out of reset.
`define TWET_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition implies a property at the following clock edge.
`define TWET_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

@@ rtl/core/twet_pkg.sv @@
// Package for the timed-wait expiry table: entry type, request and result codes.
// Used by twet_cell and timed_wait_expiry_table_top; depends on nothing.
`timescale 1ns / 1ps

package twet_pkg;

	// One waiting thread as it is held in a cell.
	typedef struct packed {
		logic [7:0]  thr;
		logic [7:0]  sem;
		logic [15:0] ticks;
	} entry_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

	// Request codes.
	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_TICK   = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	// Result kind codes.
	localparam logic [2:0] KIND_ADDED   = 3'd0;
	localparam logic [2:0] KIND_FULL    = 3'd1;
	localparam logic [2:0] KIND_REMOVED = 3'd2;
	localparam logic [2:0] KIND_EXPIRED = 3'd3;
	localparam logic [2:0] KIND_NONE    = 3'd4;

endpackage

@@ rtl/core/timed_wait_expiry_table_top.sv @@
// Top level of the timed-wait expiry table: sequencer, result register, cell chain.
// Depends on twet_pkg, twet_cell and assert_macros.svh.
`timescale 1ns / 1ps
//
//  Channel | Handshake            | Payload
//  req     | req_valid, req_stall | req_type, thread_id, timeout, sem_id
//  res     | res_valid, res_stall | kind, thread_id_out, sem_id_out, occupancy, last
//
// An add gives its result in the cycle after it is accepted.
// A tick or remove walks the whole table through cell 0, one entry per cycle while
// the result register is not stalled; an expiry is reported one expiry late,
// so the final one can carry last.
// Reset clears the entry count and sequencer; cell contents need no clearing.
// A stalled result register freezes the walk; requests are taken only when idle.

`include "assert_macros.svh"

module timed_wait_expiry_table_top
	import twet_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  thread_id,
	input  logic [15:0] timeout,
	input  logic [7:0]  sem_id,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  kind,
	output logic [7:0]  thread_id_out,
	output logic [7:0]  sem_id_out,
	output logic [4:0]  occupancy,
	output logic        last
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PASS,
		ST_FINISH
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rem_q;
	logic [CW-1:0] kept_q;
	logic [CW-1:0] occ_q;
	logic [1:0]    op_q;
	logic [7:0]    thr_q;
	logic          pend_valid_q;
	logic [7:0]    pend_thr_q;
	logic [7:0]    pend_sem_q;
	logic [CW-1:0] pend_occ_q;
	logic          res_valid_q;
	logic [2:0]    kind_q;
	logic [7:0]    thr_out_q;
	logic [7:0]    sem_out_q;
	logic [CW-1:0] occ_out_q;
	logic          last_q;

	entry_t        ents [DEPTH];
	cell_ctrl_t    ctrls [DEPTH];
	entry_t        ld_entry;
	entry_t        head;
	entry_t        kept_entry;
	logic          out_free;
	logic          req_acc;
	logic          step;
	logic          keep;
	logic          expire;
	logic [15:0]   dec_ticks;
	logic [CW-1:0] wptr;
	logic          add_ok;
	logic          res_load;

	// Handshake and walk conditions.
	assign out_free  = !res_valid_q || !res_stall;
	assign req_stall = !((state_q == ST_IDLE) && out_free);
	assign req_acc   = req_valid && !req_stall;
	assign step      = (state_q == ST_PASS) && (rem_q != '0) && out_free;
	assign add_ok    = req_acc && (req_type == REQ_ADD) && (count_q < CW'(DEPTH));

	// Decide the fate of the head entry during a walk.
	assign head      = ents[0];
	assign dec_ticks = head.ticks - 16'd1;
	assign expire    = (op_q == REQ_TICK) && (dec_ticks == 16'd0);
	assign keep      = (op_q == REQ_TICK) ? !expire : (head.thr != thr_q);
	assign wptr      = CW'(rem_q - CW'(1) + kept_q);

	// The result register takes a new transaction on an add, on every expiry but
	// the held one, and when a walk finishes.
	assign res_load  = (req_acc && (req_type == REQ_ADD))
		|| (step && expire && pend_valid_q)
		|| ((state_q == ST_FINISH) && out_free);

	always_comb begin
		kept_entry = head;
		if (op_q == REQ_TICK) begin
			kept_entry.ticks = dec_ticks;
		end
	end

	// New entries on add, surviving entries during a walk.
	always_comb begin
		if (state_q == ST_IDLE) begin
			ld_entry.thr   = thread_id;
			ld_entry.sem   = sem_id;
			ld_entry.ticks = timeout;
		end else begin
			ld_entry = kept_entry;
		end
	end

	// Cell chain: each cell takes its neighbor's entry on a shift.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t nb;
		assign nb = (i < DEPTH - 1) ? ents[(i < DEPTH - 1) ? i + 1 : i] : '0;
		assign ctrls[i].shift = step;
		assign ctrls[i].load  = (add_ok && (count_q[IW-1:0] == IW'(i)))
			|| (step && keep && (wptr[IW-1:0] == IW'(i)));
		twet_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrls[i]),
			.nb_entry (nb),
			.ld_entry (ld_entry),
			.ent_q    (ents[i])
		);
	end

	// Sequencer, pending expiry and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
			rem_q        <= '0;
			kept_q       <= '0;
			occ_q        <= '0;
			op_q         <= REQ_ADD;
			thr_q        <= '0;
			pend_thr_q   <= '0;
			pend_sem_q   <= '0;
			pend_occ_q   <= '0;
			kind_q       <= KIND_ADDED;
			thr_out_q    <= '0;
			sem_out_q    <= '0;
			occ_out_q    <= '0;
			last_q       <= 1'b0;
		end else begin
			res_valid_q <= res_load || (res_valid_q && res_stall);
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						op_q   <= req_type;
						thr_q  <= thread_id;
						rem_q  <= count_q;
						kept_q <= '0;
						occ_q  <= count_q;
						case (req_type)
							REQ_ADD: begin
								thr_out_q   <= thread_id;
								sem_out_q   <= sem_id;
								last_q      <= 1'b1;
								if (add_ok) begin
									count_q   <= count_q + CW'(1);
									kind_q    <= KIND_ADDED;
									occ_out_q <= count_q + CW'(1);
								end else begin
									kind_q    <= KIND_FULL;
									occ_out_q <= count_q;
								end
							end
							REQ_TICK, REQ_REMOVE: begin
								state_q <= ST_PASS;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_PASS: begin
					if (rem_q == '0) begin
						state_q <= ST_FINISH;
					end else if (step) begin
						rem_q <= rem_q - CW'(1);
						if (keep) begin
							kept_q <= kept_q + CW'(1);
						end
						if (expire) begin
							occ_q        <= occ_q - CW'(1);
							pend_valid_q <= 1'b1;
							pend_thr_q   <= head.thr;
							pend_sem_q   <= head.sem;
							pend_occ_q   <= occ_q - CW'(1);
							if (pend_valid_q) begin
								kind_q      <= KIND_EXPIRED;
								thr_out_q   <= pend_thr_q;
								sem_out_q   <= pend_sem_q;
								occ_out_q   <= pend_occ_q;
								last_q      <= 1'b0;
							end
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						count_q     <= kept_q;
						last_q      <= 1'b1;
						if (op_q == REQ_REMOVE) begin
							kind_q    <= KIND_REMOVED;
							thr_out_q <= thr_q;
							sem_out_q <= '0;
							occ_out_q <= kept_q;
						end else if (pend_valid_q) begin
							pend_valid_q <= 1'b0;
							kind_q       <= KIND_EXPIRED;
							thr_out_q    <= pend_thr_q;
							sem_out_q    <= pend_sem_q;
							occ_out_q    <= pend_occ_q;
						end else begin
							kind_q    <= KIND_NONE;
							thr_out_q <= '0;
							sem_out_q <= '0;
							occ_out_q <= kept_q;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result ports.
	assign res_valid     = res_valid_q;
	assign kind          = kind_q;
	assign thread_id_out = thr_out_q;
	assign sem_id_out    = sem_out_q;
	assign occupancy     = 5'(occ_out_q);
	assign last          = last_q;

	// The table never holds more entries than it has cells.
	`TWET_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "entry count exceeds depth")
	// The entry count never changes during a walk; a walk updates it when it finishes.
	`TWET_ASSERT_NEXT(a_count_hold, state_q == ST_PASS, $stable(count_q), "count changed mid-walk")
	// Entries kept plus entries still to visit never exceed the table.
	`TWET_ASSERT(a_walk_bound, (state_q != ST_PASS)
		|| (({1'b0, kept_q} + {1'b0, rem_q}) <= {1'b0, count_q}), "walk counters overrun")
	// A held expiry exists only inside a tick walk.
	`TWET_ASSERT(a_pend_tick, !pend_valid_q
		|| ((op_q == REQ_TICK) && (state_q != ST_IDLE)), "pending expiry outside tick")

endmodule

@@ rtl/core/twet_cell.sv @@
// One cell of the wait table chain: holds one entry and shifts toward the head.
// Depends on twet_pkg.
`timescale 1ns / 1ps

module twet_cell
	import twet_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  entry_t     nb_entry,
	input  entry_t     ld_entry,
	output entry_t     ent_q
);

	// A load takes a new or surviving entry; otherwise a shift takes the neighbor's.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			ent_q <= ld_entry;
		end else if (ctrl.shift) begin
			ent_q <= nb_entry;
		end
	end

endmodule

@@ tb/timed_wait_expiry_table_top_tb.sv @@
// Self-checking testbench for timed_wait_expiry_table_top: bursty request driver,
// stalling result monitor and a table predictor. Depends on twet_pkg and the block RTL.
`timescale 1ns / 1ps

module timed_wait_expiry_table_top_tb;
	import twet_pkg::*;

	localparam int DEPTH      = 16;
	localparam int HALF_CLK   = 6;
	localparam int RST_CYCLES = 12;
	localparam int HOLDOFF_AT = 40;
	localparam int HOLDOFF_LEN = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam longint LIMIT_NS = 64'd400000 * 12;

	// One request as queued for the driver; drain_first holds it back until
	// every outstanding result has arrived.
	typedef struct {
		logic [1:0]  req_type;
		logic [7:0]  thread_id;
		logic [15:0] timeout;
		logic [7:0]  sem_id;
		bit          drain_first;
	} wait_req_t;

	// One result transaction as the block should present it.
	typedef struct {
		logic [2:0] kind;
		logic [7:0] thr;
		logic [7:0] sem;
		logic [4:0] occ;
		logic       last;
	} wait_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  req_type = REQ_ADD;
	logic [7:0]  thread_id = '0;
	logic [15:0] timeout = 16'd1;
	logic [7:0]  sem_id = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  thread_id_out;
	logic [7:0]  sem_id_out;
	logic [4:0]  occupancy;
	logic        last;

	wait_req_t pending_reqs[$];
	wait_res_t expected_results[$];
	wait_req_t cur_req;
	wait_res_t got_res;
	wait_res_t exp_res;

	// Predicted contents of the wait table, packed at the front.
	logic [7:0]  tbl_thr[DEPTH];
	logic [7:0]  tbl_sem[DEPTH];
	logic [15:0] tbl_ticks[DEPTH];
	int          tbl_count = 0;

	int mismatches = 0;
	int reqs_accepted = 0;
	int burst_left = 0;
	int gap_left = 0;
	int rx_cycle = 0;
	int rx_mode = 0;
	int holdoff_left = 0;
	bit holdoff_done = 1'b0;

	timed_wait_expiry_table_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req_type      (req_type),
		.thread_id     (thread_id),
		.timeout       (timeout),
		.sem_id        (sem_id),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.kind          (kind),
		.thread_id_out (thread_id_out),
		.sem_id_out    (sem_id_out),
		.occupancy     (occupancy),
		.last          (last)
	);

	always #HALF_CLK clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("[%0t] %s", $time, msg);
		mismatches++;
	endtask

	task automatic queue_req(input logic [1:0] rt, input logic [7:0] thr,
			input logic [15:0] tmo, input logic [7:0] sem, input bit drain);
		wait_req_t rq;
		rq.req_type    = rt;
		rq.thread_id   = thr;
		rq.timeout     = tmo;
		rq.sem_id      = sem;
		rq.drain_first = drain;
		pending_reqs.push_back(rq);
	endtask

	task automatic push_result(input logic [2:0] k, input logic [7:0] thr,
			input logic [7:0] sem, input int occ, input logic lst);
		wait_res_t rs;
		rs.kind = k;
		rs.thr  = thr;
		rs.sem  = sem;
		rs.occ  = occ[4:0];
		rs.last = lst;
		expected_results.push_back(rs);
	endtask

	// Applies one accepted request to the predicted table and queues its results.
	task automatic predict_table(input wait_req_t rq);
		logic [15:0] t;
		logic [7:0]  x_thr[DEPTH];
		logic [7:0]  x_sem[DEPTH];
		int          x_occ[DEPTH];
		int          w;
		int          k;
		int          occ;
		w = 0;
		k = 0;
		case (rq.req_type)
			REQ_ADD: begin
				if (tbl_count >= DEPTH) begin
					push_result(KIND_FULL, rq.thread_id, rq.sem_id, tbl_count, 1'b1);
				end else begin
					tbl_thr[tbl_count]   = rq.thread_id;
					tbl_sem[tbl_count]   = rq.sem_id;
					tbl_ticks[tbl_count] = rq.timeout;
					tbl_count++;
					push_result(KIND_ADDED, rq.thread_id, rq.sem_id, tbl_count, 1'b1);
				end
			end
			REQ_TICK: begin
				// Expiring entries are reported in table order; survivors slide down.
				occ = tbl_count;
				for (int i = 0; i < tbl_count; i++) begin
					t = tbl_ticks[i] - 16'd1;
					if (t == 16'd0) begin
						occ--;
						x_thr[k] = tbl_thr[i];
						x_sem[k] = tbl_sem[i];
						x_occ[k] = occ;
						k++;
					end else begin
						tbl_thr[w]   = tbl_thr[i];
						tbl_sem[w]   = tbl_sem[i];
						tbl_ticks[w] = t;
						w++;
					end
				end
				tbl_count = w;
				if (k == 0) begin
					push_result(KIND_NONE, 8'd0, 8'd0, tbl_count, 1'b1);
				end else begin
					for (int j = 0; j < k; j++)
						push_result(KIND_EXPIRED, x_thr[j], x_sem[j], x_occ[j], j == k - 1);
				end
			end
			REQ_REMOVE: begin
				// Every entry of the thread goes; one acknowledgement either way.
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl_thr[i] != rq.thread_id) begin
						tbl_thr[w]   = tbl_thr[i];
						tbl_sem[w]   = tbl_sem[i];
						tbl_ticks[w] = tbl_ticks[i];
						w++;
					end
				end
				tbl_count = w;
				push_result(KIND_REMOVED, rq.thread_id, 8'd0, tbl_count, 1'b1);
			end
			default: begin
			end
		endcase
	endtask

	// Request driver: bursts of random length with random gaps, payload held while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				predict_table(cur_req);
				reqs_accepted++;
				burst_left--;
				if (burst_left <= 0) begin
					gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
						: $urandom_range(0, 4);
					burst_left = $urandom_range(1, 16);
				end
			end
			if (!(req_valid && req_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() != 0 &&
						(!pending_reqs[0].drain_first || expected_results.size() == 0)) begin
					cur_req = pending_reqs.pop_front();
					req_valid <= 1'b1;
					req_type  <= cur_req.req_type;
					thread_id <= cur_req.thread_id;
					timeout   <= cur_req.timeout;
					sem_id    <= cur_req.sem_id;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: one long hold-off once the run is under way, otherwise a
	// randomly chosen stall mode.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			rx_cycle++;
			if (!holdoff_done && reqs_accepted >= HOLDOFF_AT) begin
				holdoff_done = 1'b1;
				holdoff_left = HOLDOFF_LEN;
			end
			if (rx_cycle % 80 == 0)
				rx_mode = $urandom_range(0, 2);
			if (holdoff_left > 0) begin
				holdoff_left--;
				res_stall <= 1'b1;
			end else begin
				case (rx_mode)
					0: res_stall <= 1'b0;
					1: res_stall <= ($urandom_range(0, 99) < 40);
					default: res_stall <= (rx_cycle % 4 != 0);
				endcase
			end
		end
	end

	// Result monitor: each accepted transaction against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			got_res.kind = kind;
			got_res.thr  = thread_id_out;
			got_res.sem  = sem_id_out;
			got_res.occ  = occupancy;
			got_res.last = last;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d thread %0d",
					got_res.kind, got_res.thr));
			end else begin
				exp_res = expected_results.pop_front();
				if (got_res.kind !== exp_res.kind)
					report_mismatch($sformatf("kind got %0d exp %0d",
						got_res.kind, exp_res.kind));
				if (got_res.thr !== exp_res.thr)
					report_mismatch($sformatf("thread_id_out got %0d exp %0d",
						got_res.thr, exp_res.thr));
				if (got_res.sem !== exp_res.sem)
					report_mismatch($sformatf("sem_id_out got %0d exp %0d",
						got_res.sem, exp_res.sem));
				if (got_res.occ !== exp_res.occ)
					report_mismatch($sformatf("occupancy got %0d exp %0d",
						got_res.occ, exp_res.occ));
				if (got_res.last !== exp_res.last)
					report_mismatch($sformatf("last got %0d exp %0d",
						got_res.last, exp_res.last));
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int r;
		int add_pct;
		int tick_pct;
		logic [1:0]  rt;
		logic [7:0]  thr;
		logic [15:0] tmo;

		// Directed: field extremes, expiry, tick with no expiry, absent and duplicate removal.
		queue_req(REQ_ADD, 8'd0, 16'd1, 8'd0, 1'b0);
		queue_req(REQ_ADD, 8'd255, 16'd65535, 8'd255, 1'b0);
		queue_req(REQ_TICK, 8'h3c, 16'hffff, 8'ha5, 1'b0);
		queue_req(REQ_TICK, 8'hc3, 16'h0001, 8'h5a, 1'b0);
		queue_req(REQ_REMOVE, 8'd77, 16'd9, 8'haa, 1'b0);
		queue_req(REQ_ADD, 8'd5, 16'd2, 8'd9, 1'b0);
		queue_req(REQ_ADD, 8'd5, 16'd3, 8'd10, 1'b0);
		queue_req(REQ_REMOVE, 8'd5, 16'd0, 8'hff, 1'b0);
		// Fill the table, overflow it, then expire all but the long waiter at once.
		for (int i = 1; i < DEPTH; i++)
			queue_req(REQ_ADD, 8'(i), 16'd1, 8'(i * 16), 1'b0);
		queue_req(REQ_ADD, 8'd200, 16'd7, 8'd123, 1'b0);
		queue_req(REQ_TICK, 8'd0, 16'd0, 8'd0, 1'b0);
		queue_req(REQ_REMOVE, 8'd255, 16'd1, 8'd1, 1'b0);

		// Random: phases that lean toward filling or toward draining the table.
		for (int p = 0; p < 5; p++) begin
			add_pct  = (p % 2 == 0) ? 65 : 30;
			tick_pct = (p % 2 == 0) ? 20 : 55;
			for (int n = 0; n < 25; n++) begin
				r = $urandom_range(0, 99);
				if (r < add_pct)
					rt = REQ_ADD;
				else if (r < add_pct + tick_pct)
					rt = REQ_TICK;
				else
					rt = REQ_REMOVE;
				thr = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(0, 7));
				tmo = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535))
					: 16'($urandom_range(1, 6));
				queue_req(rt, thr, tmo, 8'($urandom), n == 0);
			end
		end

		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog for a hung handshake or missing results.
	initial begin
		#(LIMIT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ timed_wait_expiry_table_top.f @@
+incdir+rtl/core
rtl/core/twet_pkg.sv
rtl/core/twet_cell.sv
rtl/core/timed_wait_expiry_table_top.sv
tb/timed_wait_expiry_table_top_tb.sv
